/* sv/ptrain_pkg.sv */
// ----------------------------------------------------------------------------
// ptrain_pkg: shared types and constants for the perceptron training step
// widths of the fixed-point datapath, controller states and lane control
// ----------------------------------------------------------------------------
`default_nettype none

package ptrain_pkg;

  localparam int NUM_FEATURES = 8;   // lanes in use, 1 to MAX_FEATURES
  localparam int MAX_FEATURES = 8;   // feature slots carried on the stream

  localparam int FEAT_W   = 16;                      // Q8.8 feature
  localparam int WEIGHT_W = 32;                      // Q16.16 weight
  localparam int RATE_W   = 16;                      // Q0.16 rate
  localparam int PROD_W   = WEIGHT_W + FEAT_W;       // Q24.24 product
  localparam int SUM_W    = PROD_W + $clog2(NUM_FEATURES) + 1;
  localparam int SCALED_W = RATE_W + FEAT_W + 1;     // rate times feature
  localparam int ERR_W    = WEIGHT_W + 1;            // label minus dot
  localparam int ERR_LO_W = 16;                      // low part of split error
  localparam int PART_W   = SCALED_W + ERR_W - ERR_LO_W;
  localparam int TOT_W    = PART_W + ERR_LO_W + 1;
  localparam int DOT_SHIFT = 8;
  localparam int UPD_SHIFT = 24;

  localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;
  localparam logic signed [ERR_W-1:0] Q16_ONE = 33'sd65536;
  localparam logic CMD_TRAIN = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_PART,
    ST_UPD
  } state_t;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic load;   // sample accepted: form products
    logic part;   // form partial update products
    logic upd;    // write updated weights
  } lane_ctrl_t;

  typedef struct packed {
    logic decision;
    logic miss;
    logic upd;
  } verdict_t;

endpackage

`default_nettype wire

/* sv/ptrain_lane.sv */
// ----------------------------------------------------------------------------
// ptrain_lane: one weight and its multipliers
// holds one q16.16 weight, forms weight times feature and the weight update
// ----------------------------------------------------------------------------
`default_nettype none

module ptrain_lane (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire ptrain_pkg::lane_ctrl_t              ctrl,
  input  wire logic signed [ptrain_pkg::FEAT_W-1:0] feature,
  input  wire logic [ptrain_pkg::RATE_W-1:0]        rate,
  input  wire logic signed [ptrain_pkg::ERR_W-1:0]  err,
  output ptrain_pkg::prod_t                        prod
);

  localparam int WSUM_W = ptrain_pkg::TOT_W - ptrain_pkg::UPD_SHIFT + 1;
  localparam int WW     = ptrain_pkg::WEIGHT_W;

  logic signed [WW-1:0]                   weight;
  logic signed [ptrain_pkg::SCALED_W-1:0] scaled;
  logic signed [ptrain_pkg::PART_W-1:0]   p_lo;
  logic signed [ptrain_pkg::PART_W-1:0]   p_hi;
  logic signed [ptrain_pkg::TOT_W-1:0]    total;
  logic signed [WSUM_W-2:0]               delta;
  logic signed [WSUM_W-1:0]               wsum;
  logic signed [WW-1:0]                   weight_next;

  // error split into a signed high part and an unsigned low part
  logic signed [ptrain_pkg::ERR_W-ptrain_pkg::ERR_LO_W-1:0] err_hi;
  logic signed [ptrain_pkg::ERR_LO_W:0]                     err_lo;

  assign err_hi = $signed(err[ptrain_pkg::ERR_W-1:ptrain_pkg::ERR_LO_W]);
  assign err_lo = $signed({1'b0, err[ptrain_pkg::ERR_LO_W-1:0]});

  always_comb begin
    total = (ptrain_pkg::TOT_W'(p_hi) <<< ptrain_pkg::ERR_LO_W)
          + ptrain_pkg::TOT_W'(p_lo);
    delta = $signed(total[ptrain_pkg::TOT_W-1:ptrain_pkg::UPD_SHIFT]);
    wsum  = WSUM_W'(weight) + WSUM_W'(delta);
    if (wsum[WSUM_W-1:WW-1] != {(WSUM_W-WW+1){wsum[WSUM_W-1]}}) begin
      weight_next = wsum[WSUM_W-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      weight_next = wsum[WW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctrl.upd) begin
      weight <= weight_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod   <= weight * feature;
      scaled <= $signed({1'b0, rate}) * feature;
    end
    if (ctrl.part) begin
      p_lo <= scaled * err_lo;
      p_hi <= scaled * err_hi;
    end
  end

endmodule

`default_nettype wire

/* sv/ptrain_merge.sv */
// ----------------------------------------------------------------------------
// ptrain_merge: dot product and decision
// sums the lane products, rescales and saturates, decides and forms the error
// ----------------------------------------------------------------------------
`default_nettype none

module ptrain_merge (
  input  wire                                       clk,
  input  wire                                       en,
  input  wire ptrain_pkg::prod_t                    prod [ptrain_pkg::NUM_FEATURES],
  input  wire                                       label,
  input  wire                                       train,
  output logic signed [ptrain_pkg::WEIGHT_W-1:0]    dot,
  output ptrain_pkg::verdict_t                      verdict,
  output ptrain_pkg::verdict_t                      verdict_next,
  output logic signed [ptrain_pkg::ERR_W-1:0]       err
);

  localparam int SW = ptrain_pkg::SUM_W;
  localparam int WW = ptrain_pkg::WEIGHT_W;

  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] shifted;
  logic signed [WW-1:0] dot_next;

  always_comb begin
    acc = '0;
    for (int i = 0; i < ptrain_pkg::NUM_FEATURES; i++) begin
      acc = acc + SW'(prod[i]);
    end
    shifted = acc >>> ptrain_pkg::DOT_SHIFT;
    if (shifted[SW-1:WW-1] != {(SW-WW+1){shifted[SW-1]}}) begin
      dot_next = shifted[SW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      dot_next = shifted[WW-1:0];
    end
    verdict_next.decision = ~dot_next[WW-1];
    verdict_next.miss     = verdict_next.decision != label;
    verdict_next.upd      = train & verdict_next.miss;
  end

  // error from the held dot product, used while the weights are updated
  assign err = (label ? ptrain_pkg::Q16_ONE : -ptrain_pkg::Q16_ONE)
             - ptrain_pkg::ERR_W'(dot);

  always_ff @(posedge clk) begin
    if (en) begin
      dot     <= dot_next;
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

/* sv/perceptron_train_step_top.sv */
// ----------------------------------------------------------------------------
// perceptron_train_step_top: online perceptron training step
// classifies one labelled sample against stored q16.16 weights and, when
// training on a wrong decision, updates every weight in its own lane
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: label, feature_0..7; tuser: command
//  m_*      out  m_tvalid/m_tready  tdata: decision, mispredicted, dot, updated
//  cfg_*    in   cfg_wen            cfg_wdata: learning_rate
//
//  a sample passes the lane products, then the summing merge stage, which
//  waits for a free output register; a training sample with a wrong decision
//  also passes the split error multiply and the weight write in every lane
//  the weight feedback loop makes the next sample wait until this one is done
//  rst clears the weights, the rate (to 655) and all control state
//  a stalled output beat holds its result; a new sample is still taken and
//  waits in the merge stage until the output register is free
//
`default_nettype none

module perceptron_train_step_top (
  input  wire          clk,
  input  wire          rst,
  // sample stream
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [135:0] s_tdata,   // label[0], feature_0[16:1] .. feature_7[128:113]
  input  wire  [0:0]   s_tuser,   // command[0]
  // result stream
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [39:0]  m_tdata,   // decision[0], mispredicted[1], dot_product[33:2],
                                  // weights_updated[34]
  // rate register
  input  wire          cfg_wen,
  input  wire  [15:0]  cfg_wdata
);

  ptrain_pkg::state_t state, state_next;
  ptrain_pkg::lane_ctrl_t ctrl;
  ptrain_pkg::verdict_t verdict, verdict_next;
  ptrain_pkg::prod_t prod [ptrain_pkg::NUM_FEATURES];

  logic [ptrain_pkg::RATE_W-1:0]          learning_rate;
  logic signed [ptrain_pkg::WEIGHT_W-1:0] dot;
  logic signed [ptrain_pkg::ERR_W-1:0]    err;
  logic label_q;
  logic train_q;
  logic out_free;
  logic merge_en;

  // output register may be reloaded once its beat is gone or going
  assign out_free = ~m_tvalid | m_tready;

  // rate register; the user must write it only between samples, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= ptrain_pkg::RATE_RESET;
    end else if (cfg_wen) begin
      learning_rate <= cfg_wdata;
    end
  end

  // sample flags kept for the merge stage
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      label_q <= s_tdata[0];
      train_q <= s_tuser[0] == ptrain_pkg::CMD_TRAIN;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptrain_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    merge_en   = 1'b0;
    ctrl       = '0;
    case (state)
      ptrain_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        ctrl.load = s_tvalid;
        if (s_tvalid) begin
          state_next = ptrain_pkg::ST_SUM;
        end
      end
      ptrain_pkg::ST_SUM: begin
        // hold the products until the previous result has left
        if (out_free) begin
          merge_en   = 1'b1;
          state_next = verdict_next.upd ? ptrain_pkg::ST_PART : ptrain_pkg::ST_IDLE;
        end
      end
      ptrain_pkg::ST_PART: begin
        ctrl.part  = 1'b1;
        state_next = ptrain_pkg::ST_UPD;
      end
      ptrain_pkg::ST_UPD: begin
        ctrl.upd   = 1'b1;
        state_next = ptrain_pkg::ST_IDLE;
      end
      default: begin
        state_next = ptrain_pkg::ST_IDLE;
      end
    endcase
  end

  // one lane per feature
  for (genvar g = 0; g < ptrain_pkg::NUM_FEATURES; g++) begin : g_lane
    ptrain_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .feature ($signed(s_tdata[ptrain_pkg::FEAT_W*g+1 +: ptrain_pkg::FEAT_W])),
      .rate    (learning_rate),
      .err     (err),
      .prod    (prod[g])
    );
  end

  // merge stage: its registers are also the output payload
  ptrain_merge u_merge (
    .clk          (clk),
    .en           (merge_en),
    .prod         (prod),
    .label        (label_q),
    .train        (train_q),
    .dot          (dot),
    .verdict      (verdict),
    .verdict_next (verdict_next),
    .err          (err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (merge_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'd0, verdict.upd, dot, verdict.miss, verdict.decision};

  // a weight write only follows a result that asked for one
  a_upd_flagged: assert property (@(posedge clk) disable iff (rst)
    (state == ptrain_pkg::ST_UPD) |-> verdict.upd)
    else $error("weight write without an update verdict");

  // an accepted sample moves straight to the merge stage
  a_accept_sum: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ptrain_pkg::ST_SUM))
    else $error("accepted sample did not reach the merge stage");

  // an update is only reported for a wrong decision
  a_upd_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[34] || m_tdata[1]))
    else $error("weights updated on a correct decision");

endmodule

`default_nettype wire
